>>> rtl/core/splitmix64_rng_with_range_macros.svh
// Assertion macros used by the splitmix64 range generator controller
`ifndef SPLITMIX64_RNG_WITH_RANGE_MACROS_SVH
`define SPLITMIX64_RNG_WITH_RANGE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define SM64_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sm64 same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet during reset
`define SM64_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sm64 next-cycle check failed");

`endif

>>> rtl/core/sm64_pkg.sv
// Package: types, codes and constants of the splitmix64 range generator
package sm64_pkg;

	// Generator constants
	localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;
	localparam logic [63:0] DEFAULT_SEED = 64'h853c49e6748fea9b;

	// Request codes
	localparam logic [1:0] CMD_RAW   = 2'd0;
	localparam logic [1:0] CMD_RANGE = 2'd1;
	localparam logic [1:0] CMD_FRAC  = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// Sequencing limits
	localparam logic [1:0] MUL_LAST = 2'd2;
	localparam logic [5:0] DIV_LAST = 6'd63;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [63:0] min_value;
		logic signed [63:0] max_value;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] result_value;
		logic [52:0]        unit_fraction;
	} out_item_t;

	// Datapath operations
	typedef enum logic [3:0] {
		DP_IDLE,
		DP_LOAD,
		DP_ADVANCE,
		DP_MUL,
		DP_MIXA,
		DP_MIXB,
		DP_DIV,
		DP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] step;
		logic       mul_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       empty_range;
		logic       span_zero;
	} dp_stat_t;

endpackage

>>> rtl/core/sm64_ctrl.sv
// Controller: sequences draw, multiply, divide and output steps
`include "splitmix64_rng_with_range_macros.svh"

module sm64_ctrl
	import sm64_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  dcmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECIDE = 8'b0000_0010,
		S_MULA   = 8'b0000_0100,
		S_MIXA   = 8'b0000_1000,
		S_MULB   = 8'b0001_0000,
		S_MIXB   = 8'b0010_0000,
		S_DIV    = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t     state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic       out_valid_q, out_valid_d;
	logic       skip;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	assign skip      = (stat.cmd == CMD_NONE) || ((stat.cmd == CMD_RANGE) && stat.empty_range);

	// Next state and datapath command
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		out_valid_d  = out_valid_q && !out_ready;
		dcmd.op      = DP_IDLE;
		dcmd.step    = cnt_q[1:0];
		dcmd.mul_sel = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					dcmd.op = DP_LOAD;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cnt_d = '0;
				if (skip) begin
					state_d = S_DONE;
				end else begin
					dcmd.op = DP_ADVANCE;
					state_d = S_MULA;
				end
			end
			S_MULA: begin
				dcmd.op = DP_MUL;
				if (cnt_q[1:0] == MUL_LAST) begin
					cnt_d   = '0;
					state_d = S_MIXA;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			S_MIXA: begin
				dcmd.op = DP_MIXA;
				state_d = S_MULB;
			end
			S_MULB: begin
				dcmd.op      = DP_MUL;
				dcmd.mul_sel = 1'b1;
				if (cnt_q[1:0] == MUL_LAST) begin
					cnt_d   = '0;
					state_d = S_MIXB;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			S_MIXB: begin
				dcmd.op = DP_MIXB;
				if ((stat.cmd == CMD_RANGE) && !stat.span_zero) begin
					state_d = S_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				dcmd.op = DP_DIV;
				if (cnt_q == DIV_LAST) begin
					cnt_d   = '0;
					state_d = S_DONE;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			S_DONE: begin
				// hold until the output register is free
				if (out_free) begin
					dcmd.op     = DP_OUT;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	`SM64_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`SM64_ASSERT_NOW(a_out_only_when_free, dcmd.op == DP_OUT, out_free)
	`SM64_ASSERT_NOW(a_advance_not_skipped, dcmd.op == DP_ADVANCE, !skip)
	`SM64_ASSERT_NEXT(a_div_ends_in_done, (state_q == S_DIV) && (cnt_q == DIV_LAST),
		state_q == S_DONE)

endmodule

>>> rtl/core/sm64_dp.sv
// Datapath: generator state, shared 32x32 multiplier, restoring divider, output register
module sm64_dp
	import sm64_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  in_item_t    in_data,
	input  dp_cmd_t     dcmd,
	output dp_stat_t    stat,
	output out_item_t   out_data
);

	logic [63:0]        state_q;
	logic [63:0]        z_q;
	logic [63:0]        acc_q;
	logic [63:0]        word_q;
	logic [63:0]        dvd_q;
	logic [63:0]        rem_q;
	logic [63:0]        span_q;
	logic signed [63:0] lo_q;
	logic signed [63:0] hi_q;
	logic [1:0]         cmd_q;
	out_item_t          out_q;

	logic [63:0] adv;
	logic [63:0] mul_b;
	logic [31:0] mul_x;
	logic [31:0] mul_y;
	logic [63:0] prod;
	logic [63:0] word_mix;
	logic [64:0] rem_sh;
	logic        rem_ge;
	out_item_t   out_d;

	assign stat.cmd         = cmd_q;
	assign stat.empty_range = (lo_q >= hi_q);
	assign stat.span_zero   = (span_q == 64'd0);
	assign out_data         = out_q;

	// Advance by the golden gamma; the first xor-shift is applied where z_q is loaded
	assign adv = state_q + GOLDEN_GAMMA;

	// Pick partial-product operands for this step
	assign mul_b = dcmd.mul_sel ? MIX_MUL_B : MIX_MUL_A;
	always_comb begin
		mul_x = z_q[31:0];
		mul_y = mul_b[31:0];
		case (dcmd.step)
			2'd1: mul_y = mul_b[63:32];
			2'd2: mul_x = z_q[63:32];
			default: begin
				mul_x = z_q[31:0];
				mul_y = mul_b[31:0];
			end
		endcase
	end
	assign prod = mul_x * mul_y;

	assign word_mix = acc_q ^ (acc_q >> 31);

	// Restoring divide step
	assign rem_sh = {rem_q, dvd_q[63]};
	assign rem_ge = (rem_sh >= {1'b0, span_q});

	// Form the result item
	always_comb begin
		out_d = '0;
		case (cmd_q)
			CMD_RAW: out_d.result_value = word_q;
			CMD_RANGE: begin
				if (stat.empty_range) begin
					out_d.result_value = lo_q;
				end else if (stat.span_zero) begin
					out_d.result_value = lo_q + word_q;
				end else begin
					out_d.result_value = lo_q + rem_q;
				end
			end
			CMD_FRAC: out_d.unit_fraction = word_q[63:11];
			default: out_d = '0;
		endcase
	end

	// Generator state and request code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DEFAULT_SEED;
			cmd_q   <= CMD_NONE;
		end else begin
			if (cfg_we) begin
				state_q <= (cfg_wdata == 64'd0) ? DEFAULT_SEED : cfg_wdata;
			end else if (dcmd.op == DP_ADVANCE) begin
				state_q <= adv;
			end
			if (dcmd.op == DP_LOAD) begin
				cmd_q <= in_data.cmd;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (dcmd.op)
			DP_LOAD: begin
				lo_q   <= in_data.min_value;
				hi_q   <= in_data.max_value;
				span_q <= in_data.max_value - in_data.min_value + 64'd1;
			end
			DP_ADVANCE: z_q <= adv ^ (adv >> 30);
			DP_MUL: begin
				if (dcmd.step == 2'd0) begin
					acc_q <= prod;
				end else begin
					acc_q <= {acc_q[63:32] + prod[31:0], acc_q[31:0]};
				end
			end
			DP_MIXA: z_q <= acc_q ^ (acc_q >> 27);
			DP_MIXB: begin
				word_q <= word_mix;
				dvd_q  <= word_mix;
				rem_q  <= '0;
			end
			DP_DIV: begin
				dvd_q <= {dvd_q[62:0], 1'b0};
				if (rem_ge) begin
					rem_q <= rem_sh[63:0] - span_q;
				end else begin
					rem_q <= rem_sh[63:0];
				end
			end
			DP_OUT: out_q <= out_d;
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/core/splitmix64_rng_with_range.sv
// Raw and fraction requests draw and mix one word; a ranged request also runs the 64-step
// restoring divider, and a request with no draw goes straight to the output.
// The two mixing multiplies share one 32x32 multiplier, three partial products each.
// One request in flight; the next is taken in the cycle after the result is written, even if
// the previous result is still waiting in the output register.
// Reset (arst_n low, asynchronous) loads the default seed and empties the output register.
module splitmix64_rng_with_range
	import sm64_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data
);

	dp_cmd_t  dcmd;
	dp_stat_t stat;

	// Sequencer
	sm64_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.dcmd      (dcmd)
	);

	// Arithmetic and state
	sm64_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.dcmd      (dcmd),
		.stat      (stat),
		.out_data  (out_data)
	);

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the splitmix64 range generator with its own prediction
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sm64_pkg::*;

	localparam int          CYCLE_LIMIT = 600000;
	localparam int          TAIL_CYCLES = 100;
	localparam int          SETTLE_CYCLES = 8;
	localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] INT64_MAX = 64'h7fff_ffff_ffff_ffff;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [63:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;

	// Predicted generator state and results still owed by the block
	logic [63:0] gen_state;
	out_item_t   pending_results[$];

	int     error_count;
	int     send_idle_pct;
	int     recv_stall_pct;
	int     holdoff_len;
	int     holdoff_token;
	int     holdoff_seen;
	int     holdoff_left;
	longint cycle_count;

	splitmix64_rng_with_range dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Free-running clock, 10 ns period
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Step the state by the golden gamma and mix it into one output word
	function automatic logic [63:0] draw_mixed_word();
		logic [63:0] z;
		gen_state = gen_state + GOLDEN_GAMMA;
		z = gen_state;
		z = (z ^ (z >> 30)) * MIX_MUL_A;
		z = (z ^ (z >> 27)) * MIX_MUL_B;
		return z ^ (z >> 31);
	endfunction

	// Compute the result of one request and advance the predicted state
	function automatic out_item_t predict_result(in_item_t req);
		out_item_t   res;
		logic [63:0] word;
		logic [63:0] span;
		res = '0;
		case (req.cmd)
			CMD_RAW: begin
				res.result_value = draw_mixed_word();
			end
			CMD_RANGE: begin
				if ($signed(req.min_value) >= $signed(req.max_value)) begin
					res.result_value = req.min_value;
				end else begin
					span = req.max_value - req.min_value + 64'd1;
					word = draw_mixed_word();
					if (span == 64'd0)
						res.result_value = req.min_value + word;
					else
						res.result_value = req.min_value + (word % span);
				end
			end
			CMD_FRAC: begin
				word = draw_mixed_word();
				res.unit_fraction = word[63:11];
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic in_item_t make_request(logic [1:0] cmd, logic [63:0] lo, logic [63:0] hi);
		in_item_t req;
		req.cmd = cmd;
		req.min_value = lo;
		req.max_value = hi;
		return req;
	endfunction

	// Mostly ranged requests of varied span shapes; other commands carry noise bounds
	function automatic in_item_t random_request();
		in_item_t req;
		int       pick;
		pick = $urandom_range(99);
		req = make_request(CMD_RANGE, rand64(), rand64());
		if (pick < 20) begin
			req.cmd = CMD_RAW;
		end else if (pick < 35) begin
			req.cmd = CMD_FRAC;
		end else if (pick < 40) begin
			req.cmd = CMD_NONE;
		end else begin
			case ($urandom_range(4))
				0: ;
				1: req.max_value = req.min_value + 64'($urandom_range(1000));
				2: begin
					req.min_value = 64'($urandom_range(200)) - 64'd100;
					req.max_value = req.min_value + 64'($urandom_range(50));
				end
				3: req.max_value = req.min_value + ((64'd1 << $urandom_range(63)) - 64'd1);
				default: req.max_value = req.min_value;
			endcase
		end
		return req;
	endfunction

	// Offer one request, idling first at the current rate; valid stays high after the transfer
	task automatic send_request(input in_item_t req);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_ready !== 1'b1);
		pending_results.push_back(predict_result(req));
	endtask

	// Drop valid and wait until every owed result has been taken
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Reload the seed while the block is idle
	task automatic write_seed(input logic [63:0] value);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		gen_state = (value == 64'd0) ? DEFAULT_SEED : value;
	endtask

	// Draws straight out of reset use the default seed
	task automatic test_reset_seed();
		send_request(make_request(CMD_RAW, '0, '0));
		send_request(make_request(CMD_FRAC, '0, '0));
		send_request(make_request(CMD_NONE, '1, '1));
		send_request(make_request(CMD_RAW, INT64_MAX, INT64_MIN));
	endtask

	// Empty, inverted, full and wrapping spans at the signed extremes
	task automatic test_range_corners();
		send_request(make_request(CMD_RANGE, 64'd0, 64'd9));
		send_request(make_request(CMD_RANGE, 64'd5, 64'd5));
		send_request(make_request(CMD_RANGE, 64'd10, -64'sd10));
		send_request(make_request(CMD_RANGE, INT64_MAX, INT64_MIN));
		send_request(make_request(CMD_RANGE, INT64_MIN, INT64_MAX));
		send_request(make_request(CMD_RANGE, INT64_MIN, INT64_MAX - 64'd1));
		send_request(make_request(CMD_RANGE, INT64_MIN, INT64_MIN + 64'd1));
		send_request(make_request(CMD_RANGE, INT64_MAX - 64'd1, INT64_MAX));
		send_request(make_request(CMD_RANGE, -64'sd1, 64'd0));
		send_request(make_request(CMD_RANGE, -64'sd1000, 64'd1000));
		send_request(make_request(CMD_RANGE, 64'd0, (64'd1 << 62) - 64'd1));
		send_request(make_request(CMD_RANGE, INT64_MIN, -64'sd1));
		send_request(make_request(CMD_FRAC, INT64_MIN, INT64_MAX));
		send_request(make_request(CMD_RAW, '1, '0));
	endtask

	// Random requests under one seed and one idling pattern
	task automatic test_random_traffic(input logic [63:0] seed, input int count,
		input int idle_pct, input int stall_pct);
		write_seed(seed);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_request(random_request());
	endtask

	// Long receiver hold-off that backs up into the input, then a full pause before resuming
	task automatic test_output_holdoff();
		write_seed(rand64());
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holdoff_len = 500;
		holdoff_token++;
		repeat (20) send_request(random_request());
		drain_results();
		repeat (20) send_request(random_request());
	endtask

	// Receiver: random stalls, or a counted hold-off when one is requested
	always @(posedge clk) begin
		if (holdoff_token != holdoff_seen) begin
			holdoff_seen = holdoff_token;
			holdoff_left = holdoff_len;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each result transfer against the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result, expected none, actual %h / %h", $time,
					out_data.result_value, out_data.unit_fraction);
			end else begin
				want = pending_results.pop_front();
				if (out_data.result_value !== want.result_value) begin
					error_count++;
					$display("%0t: result_value expected %h actual %h", $time,
						want.result_value, out_data.result_value);
				end
				if (out_data.unit_fraction !== want.unit_fraction) begin
					error_count++;
					$display("%0t: unit_fraction expected %h actual %h", $time,
						want.unit_fraction, out_data.unit_fraction);
				end
			end
		end
	end

	// Watchdog on total run length
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holdoff_len = 0;
		holdoff_token = 0;
		holdoff_seen = 0;
		holdoff_left = 0;
		cycle_count = 0;
		gen_state = DEFAULT_SEED;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_seed();
		test_range_corners();
		test_random_traffic(64'd0, 110, 0, 0);
		test_random_traffic('1, 110, 87, 0);
		test_random_traffic(64'd1, 110, 0, 87);
		test_random_traffic(INT64_MIN, 90, 33, 33);
		test_output_holdoff();

		// Let everything owed arrive, then watch for strays
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> splitmix64_rng_with_range.f
+incdir+rtl/core
rtl/core/sm64_pkg.sv
rtl/core/sm64_ctrl.sv
rtl/core/sm64_dp.sv
rtl/core/splitmix64_rng_with_range.sv
dv/testbench.sv
